[hdl/gma_pkg.sv]
package gma_pkg;

    localparam int GRID_W    = 64;
    localparam int GRID_H    = 64;
    localparam int SPECIES_N = 4;
    localparam int CELLS     = GRID_W * GRID_H * SPECIES_N;
    localparam int AW        = $clog2(CELLS);
    localparam int XW        = $clog2(GRID_W);
    localparam int YW        = $clog2(GRID_H);
    localparam int SW        = (SPECIES_N > 1) ? $clog2(SPECIES_N) : 1;

    localparam logic [23:0] GRAVITY_RST = 24'd642908;
    localparam logic [16:0] UNIT_Q16    = 17'd65536;

    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 33;

    localparam logic [1:0] KIND_INJECT = 2'd0;
    localparam logic [1:0] KIND_UPDATE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [1:0] OFF_NEG  = 2'd0;
    localparam logic [1:0] OFF_ZERO = 2'd1;
    localparam logic [1:0] OFF_POS  = 2'd2;

    typedef struct packed {
        logic        [1:0]  kind;
        logic        [5:0]  cell_x;
        logic        [5:0]  cell_y;
        logic        [1:0]  species;
        logic        [31:0] add_mass;
        logic signed [31:0] add_vel_x;
        logic signed [31:0] add_vel_y;
        logic        [15:0] delta_time;
    } t_in_item;

    typedef struct packed {
        logic        [31:0] out_mass;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
    } t_out_item;

    typedef struct packed {
        logic [31:0] mass;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
    } t_cell;

    localparam int CELL_BITS = $bits(t_cell);

    typedef enum logic [4:0] {
        ST_RST_CLR,
        ST_IDLE,
        ST_DECODE,
        ST_INJ_LD,
        ST_UPD_CLR,
        ST_SRC_RD,
        ST_SRC_CHK,
        ST_DISP,
        ST_WGT,
        ST_SHARE,
        ST_TGT_LD,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_MRG_WR,
        ST_OFF_NEXT,
        ST_SRC_NEXT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic clr_cur;
        logic clr_oth;
        logic src_latch;
        logic src_next;
        logic disp;
        logic off_first;
        logic off_next;
        logic wgt;
        logic share;
        logic load_inj;
        logic load_upd;
        logic mul_go;
        logic wr_cur;
        logic wr_oth;
        logic flip;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] kind;
        logic       inj_skip;
        logic       src_empty;
        logic       src_last;
        logic       share_zero;
        logic       off_last;
        logic       mul_busy;
        logic       out_free;
    } t_stat;

    function automatic logic [AW-1:0] cell_addr(input int x, input int y, input int s);
        return AW'((x * GRID_H + y) * SPECIES_N + s);
    endfunction

endpackage

[hdl/gma_ram.sv]
module gma_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/gma_muldiv.sv]
module gma_muldiv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_a,
    input  logic [31:0] i_b,
    input  logic [32:0] i_c,
    output logic        o_busy,
    output logic [32:0] o_q
);

    // Computes floor(a*b/c) for b <= c: shift-add product, then restoring division.
    logic        r_busy;
    logic        r_div;
    logic [5:0]  r_cnt;
    logic [64:0] r_acc;
    logic [32:0] r_rem;
    logic [32:0] r_low;
    logic [32:0] r_a;
    logic [31:0] r_b;
    logic [32:0] r_c;

    logic [64:0] n_acc;
    logic [33:0] trial;
    logic        ge;

    assign n_acc = {r_acc[63:0], 1'b0} + (r_b[31] ? {32'd0, r_a} : 65'd0);
    assign trial = {r_rem, r_low[32]};
    assign ge    = trial >= {1'b0, r_c};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_div && r_cnt == 6'(gma_pkg::DIV_STEPS - 1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_c   <= i_c;
            r_acc <= '0;
            r_cnt <= '0;
            r_div <= 1'b0;
        end else if (r_busy && !r_div) begin
            r_acc <= n_acc;
            r_b   <= {r_b[30:0], 1'b0};
            if (r_cnt == 6'(gma_pkg::MUL_STEPS - 1)) begin
                // The upper product bits are below c, so they seed the remainder.
                r_rem <= {1'b0, n_acc[64:33]};
                r_low <= n_acc[32:0];
                r_cnt <= '0;
                r_div <= 1'b1;
            end else begin
                r_cnt <= r_cnt + 6'd1;
            end
        end else if (r_busy) begin
            r_rem <= ge ? 33'(trial - {1'b0, r_c}) : trial[32:0];
            r_low <= {r_low[31:0], ge};
            r_cnt <= r_cnt + 6'd1;
        end
    end

    assign o_busy = r_busy;
    assign o_q    = r_low;

`ifndef SYNTH
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("muldiv started while busy");
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> r_low <= r_a)
        else $error("muldiv quotient exceeds first operand");
`endif

endmodule

[hdl/gma_ctrl.sv]
module gma_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  gma_pkg::t_stat i_stat,
    output gma_pkg::t_cmd  o_cmd
);

    gma_pkg::t_state r_state;
    gma_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gma_pkg::ST_RST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            gma_pkg::ST_RST_CLR: begin
                if (i_stat.clr_last) n_state = gma_pkg::ST_IDLE;
            end
            gma_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = gma_pkg::ST_DECODE;
            end
            gma_pkg::ST_DECODE: begin
                case (i_stat.kind)
                    gma_pkg::KIND_INJECT: n_state = gma_pkg::ST_INJ_LD;
                    gma_pkg::KIND_UPDATE: n_state = gma_pkg::ST_UPD_CLR;
                    default:              n_state = gma_pkg::ST_DONE;
                endcase
            end
            gma_pkg::ST_INJ_LD: begin
                n_state = i_stat.inj_skip ? gma_pkg::ST_DONE : gma_pkg::ST_MUL_GO;
            end
            gma_pkg::ST_UPD_CLR: begin
                if (i_stat.clr_last) n_state = gma_pkg::ST_SRC_RD;
            end
            gma_pkg::ST_SRC_RD:  n_state = gma_pkg::ST_SRC_CHK;
            gma_pkg::ST_SRC_CHK: begin
                n_state = i_stat.src_empty ? gma_pkg::ST_SRC_NEXT : gma_pkg::ST_DISP;
            end
            gma_pkg::ST_DISP:  n_state = gma_pkg::ST_WGT;
            gma_pkg::ST_WGT:   n_state = gma_pkg::ST_SHARE;
            gma_pkg::ST_SHARE: n_state = gma_pkg::ST_TGT_LD;
            gma_pkg::ST_TGT_LD: begin
                n_state = i_stat.share_zero ? gma_pkg::ST_OFF_NEXT : gma_pkg::ST_MUL_GO;
            end
            gma_pkg::ST_MUL_GO: n_state = gma_pkg::ST_MUL_WAIT;
            gma_pkg::ST_MUL_WAIT: begin
                if (!i_stat.mul_busy) n_state = gma_pkg::ST_MRG_WR;
            end
            gma_pkg::ST_MRG_WR: begin
                n_state = (i_stat.kind == gma_pkg::KIND_UPDATE) ? gma_pkg::ST_OFF_NEXT
                                                                : gma_pkg::ST_DONE;
            end
            gma_pkg::ST_OFF_NEXT: begin
                n_state = i_stat.off_last ? gma_pkg::ST_SRC_NEXT : gma_pkg::ST_WGT;
            end
            gma_pkg::ST_SRC_NEXT: begin
                n_state = i_stat.src_last ? gma_pkg::ST_DONE : gma_pkg::ST_SRC_RD;
            end
            gma_pkg::ST_DONE: begin
                if (i_stat.out_free) n_state = gma_pkg::ST_IDLE;
            end
            default: n_state = gma_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            gma_pkg::ST_RST_CLR: o_cmd.clr_cur = 1'b1;
            gma_pkg::ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            gma_pkg::ST_INJ_LD:  o_cmd.load_inj  = !i_stat.inj_skip;
            gma_pkg::ST_UPD_CLR: o_cmd.clr_oth   = 1'b1;
            gma_pkg::ST_SRC_CHK: o_cmd.src_latch = !i_stat.src_empty;
            gma_pkg::ST_DISP: begin
                o_cmd.disp      = 1'b1;
                o_cmd.off_first = 1'b1;
            end
            gma_pkg::ST_WGT:    o_cmd.wgt      = 1'b1;
            gma_pkg::ST_SHARE:  o_cmd.share    = 1'b1;
            gma_pkg::ST_TGT_LD: o_cmd.load_upd = !i_stat.share_zero;
            gma_pkg::ST_MUL_GO: o_cmd.mul_go   = 1'b1;
            gma_pkg::ST_MRG_WR: begin
                if (i_stat.kind == gma_pkg::KIND_UPDATE) begin
                    o_cmd.wr_oth = 1'b1;
                end else begin
                    o_cmd.wr_cur = 1'b1;
                end
            end
            gma_pkg::ST_OFF_NEXT: o_cmd.off_next = !i_stat.off_last;
            gma_pkg::ST_SRC_NEXT: begin
                o_cmd.src_next = !i_stat.src_last;
                o_cmd.flip     = i_stat.src_last;
            end
            gma_pkg::ST_DONE: o_cmd.load_out = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

[hdl/gma_datapath.sv]
module gma_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gma_pkg::t_cmd      i_cmd,
    output gma_pkg::t_stat     o_stat,
    input  gma_pkg::t_in_item  i_in_data,
    input  logic               i_cfg_valid,
    input  logic [23:0]        i_cfg_data,
    output logic               o_out_valid,
    output gma_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);

    gma_pkg::t_in_item  r_in;
    gma_pkg::t_out_item r_out_data;
    logic               r_out_valid;
    logic [23:0]        r_gravity;
    logic [23:0]        r_g;
    logic               r_cur;
    logic [gma_pkg::AW-1:0] r_clr;

    logic [gma_pkg::XW-1:0] r_sx;
    logic [gma_pkg::YW-1:0] r_sy;
    logic [gma_pkg::SW-1:0] r_ss;

    logic [31:0] r_m;
    logic [31:0] r_vx;
    logic [31:0] r_vyg;
    logic [16:0] r_ax;
    logic [16:0] r_ay;
    logic        r_nzx, r_negx_v, r_nzy, r_negy_v;
    logic [1:0]  r_ox, r_oy;
    logic [32:0] r_w;
    logic        r_tvalid;
    logic [gma_pkg::AW-1:0] r_tgt_addr;
    logic [31:0] r_share;

    gma_pkg::t_cell r_old;
    logic [31:0] r_add;
    logic [32:0] r_tot;
    logic        r_negx, r_negy;
    logic [32:0] r_magx, r_magy;

    gma_pkg::t_cell cur_data, oth_data, rd0, rd1, mrg_data, old_sel;
    logic [gma_pkg::AW-1:0] io_addr, src_addr, raddr_c, waddr_c, waddr_o;
    logic        we_c, we_o;
    gma_pkg::t_cell wdata_c, wdata_o;
    logic        cell_ok;
    logic [32:0] vy_sub;
    logic [31:0] vyg;
    logic [31:0] magv_x, magv_y;
    logic [47:0] prod_x, prod_y;
    logic [16:0] ax, ay, wx, wy;
    int          tx, ty;
    logic [31:0] add_sel, nvx_sel, nvy_sel;
    logic [32:0] dx, dy;
    logic [32:0] qx, qy;
    logic        busy_x, busy_y;

    function automatic logic [16:0] axis_w(input logic [1:0] off, input logic nz,
                                           input logic neg, input logic [16:0] a);
        logic [16:0] w;
        w = '0;
        if (off == gma_pkg::OFF_ZERO) begin
            w = gma_pkg::UNIT_Q16 - a;
        end else if (nz && ((off == gma_pkg::OFF_NEG && neg) ||
                            (off == gma_pkg::OFF_POS && !neg))) begin
            w = a;
        end
        return w;
    endfunction

    function automatic logic [16:0] clamp_disp(input logic [47:0] p);
        return (p[47:16] > 32'd65536) ? gma_pkg::UNIT_Q16 : p[32:16];
    endfunction

    assign cell_ok  = (int'(r_in.cell_x) < gma_pkg::GRID_W) &&
                      (int'(r_in.cell_y) < gma_pkg::GRID_H) &&
                      (int'(r_in.species) < gma_pkg::SPECIES_N);
    assign io_addr  = gma_pkg::cell_addr(int'(r_in.cell_x), int'(r_in.cell_y),
                                         int'(r_in.species));
    assign src_addr = gma_pkg::cell_addr(int'(r_sx), int'(r_sy), int'(r_ss));

    // Control and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity   <= gma_pkg::GRAVITY_RST;
            r_cur       <= 1'b0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_gravity <= i_cfg_data;
            if (i_cmd.flip) r_cur <= ~r_cur;
            if (i_cmd.accept) begin
                r_clr <= '0;
            end else if (i_cmd.clr_cur || i_cmd.clr_oth) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_in <= i_in_data;
        r_g <= 24'((40'(r_gravity) * 40'(r_in.delta_time)) >> 16);
    end

    // Source sweep in x, then y, then species order, which is also address order.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sx <= '0;
            r_sy <= '0;
            r_ss <= '0;
        end else if (i_cmd.src_next) begin
            if (int'(r_ss) == gma_pkg::SPECIES_N - 1) begin
                r_ss <= '0;
                if (int'(r_sy) == gma_pkg::GRID_H - 1) begin
                    r_sy <= '0;
                    r_sx <= r_sx + 1'b1;
                end else begin
                    r_sy <= r_sy + 1'b1;
                end
            end else begin
                r_ss <= r_ss + 1'b1;
            end
        end
    end

    // Gravity with saturation at the most negative velocity.
    assign vy_sub = {cur_data.vel_y[31], cur_data.vel_y} - {9'd0, r_g};
    assign vyg    = (vy_sub[32] && !vy_sub[31]) ? 32'h8000_0000 : vy_sub[31:0];

    assign magv_x = r_vx[31] ? (32'd0 - r_vx) : r_vx;
    assign magv_y = r_vyg[31] ? (32'd0 - r_vyg) : r_vyg;
    assign prod_x = 48'(magv_x) * 48'(r_in.delta_time);
    assign prod_y = 48'(magv_y) * 48'(r_in.delta_time);
    assign ax     = clamp_disp(prod_x);
    assign ay     = clamp_disp(prod_y);

    assign tx = int'(r_sx) + int'(r_ox) - 1;
    assign ty = int'(r_sy) + int'(r_oy) - 1;
    assign wx = axis_w(r_ox, r_nzx, r_negx_v, r_ax);
    assign wy = axis_w(r_oy, r_nzy, r_negy_v, r_ay);

    always_ff @(posedge i_clk) begin
        if (i_cmd.src_latch) begin
            r_m   <= cur_data.mass;
            r_vx  <= cur_data.vel_x;
            r_vyg <= vyg;
        end
        if (i_cmd.disp) begin
            r_ax     <= ax;
            r_ay     <= ay;
            r_nzx    <= ax != '0;
            r_nzy    <= ay != '0;
            r_negx_v <= r_vx[31];
            r_negy_v <= r_vyg[31];
        end
        if (i_cmd.off_first) begin
            r_ox <= gma_pkg::OFF_NEG;
            r_oy <= gma_pkg::OFF_NEG;
        end else if (i_cmd.off_next) begin
            if (r_oy == gma_pkg::OFF_POS) begin
                r_oy <= gma_pkg::OFF_NEG;
                r_ox <= r_ox + 2'd1;
            end else begin
                r_oy <= r_oy + 2'd1;
            end
        end
        if (i_cmd.wgt) begin
            r_w        <= 33'(34'(wx) * 34'(wy));
            r_tvalid   <= tx >= 0 && tx < gma_pkg::GRID_W && ty >= 0 && ty < gma_pkg::GRID_H;
            r_tgt_addr <= gma_pkg::cell_addr(tx, ty, int'(r_ss));
        end
        if (i_cmd.share) begin
            if (!r_tvalid) begin
                r_share <= '0;
            end else if (r_w[32]) begin
                r_share <= r_m;
            end else begin
                r_share <= 32'((64'(r_m) * 64'(r_w[31:0])) >> 32);
            end
        end
    end

    // Merge operands: old cell, added mass, and velocity differences.
    assign old_sel = i_cmd.load_upd ? oth_data : cur_data;
    assign add_sel = i_cmd.load_upd ? r_share : r_in.add_mass;
    assign nvx_sel = i_cmd.load_upd ? r_vx : r_in.add_vel_x;
    assign nvy_sel = i_cmd.load_upd ? r_vyg : r_in.add_vel_y;
    assign dx = {nvx_sel[31], nvx_sel} - {old_sel.vel_x[31], old_sel.vel_x};
    assign dy = {nvy_sel[31], nvy_sel} - {old_sel.vel_y[31], old_sel.vel_y};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_upd || i_cmd.load_inj) begin
            r_old  <= old_sel;
            r_add  <= add_sel;
            r_tot  <= {1'b0, old_sel.mass} + {1'b0, add_sel};
            r_negx <= dx[32];
            r_negy <= dy[32];
            r_magx <= dx[32] ? (33'd0 - dx) : dx;
            r_magy <= dy[32] ? (33'd0 - dy) : dy;
        end
    end

    gma_muldiv u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_go),
        .i_a     (r_magx),
        .i_b     (r_add),
        .i_c     (r_tot),
        .o_busy  (busy_x),
        .o_q     (qx)
    );

    gma_muldiv u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_go),
        .i_a     (r_magy),
        .i_b     (r_add),
        .i_c     (r_tot),
        .o_busy  (busy_y),
        .o_q     (qy)
    );

    assign mrg_data.mass  = r_tot[32] ? 32'hFFFF_FFFF : r_tot[31:0];
    assign mrg_data.vel_x = r_negx ? (r_old.vel_x - qx[31:0]) : (r_old.vel_x + qx[31:0]);
    assign mrg_data.vel_y = r_negy ? (r_old.vel_y - qy[31:0]) : (r_old.vel_y + qy[31:0]);

    // Two banks: the current grid and the one being built by an update.
    assign we_c    = i_cmd.clr_cur || i_cmd.wr_cur;
    assign waddr_c = i_cmd.clr_cur ? r_clr : io_addr;
    assign wdata_c = i_cmd.clr_cur ? '0 : mrg_data;
    assign we_o    = i_cmd.clr_oth || i_cmd.wr_oth;
    assign waddr_o = i_cmd.clr_oth ? r_clr : r_tgt_addr;
    assign wdata_o = i_cmd.clr_oth ? '0 : mrg_data;
    assign raddr_c = (r_in.kind == gma_pkg::KIND_UPDATE) ? src_addr : io_addr;

    gma_ram #(
        .WIDTH (gma_pkg::CELL_BITS),
        .DEPTH (gma_pkg::CELLS)
    ) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (r_cur ? we_o : we_c),
        .i_waddr (r_cur ? waddr_o : waddr_c),
        .i_wdata (r_cur ? wdata_o : wdata_c),
        .i_raddr (r_cur ? r_tgt_addr : raddr_c),
        .o_rdata (rd0)
    );

    gma_ram #(
        .WIDTH (gma_pkg::CELL_BITS),
        .DEPTH (gma_pkg::CELLS)
    ) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (r_cur ? we_c : we_o),
        .i_waddr (r_cur ? waddr_c : waddr_o),
        .i_wdata (r_cur ? wdata_c : wdata_o),
        .i_raddr (r_cur ? raddr_c : r_tgt_addr),
        .o_rdata (rd1)
    );

    assign cur_data = r_cur ? rd1 : rd0;
    assign oth_data = r_cur ? rd0 : rd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_in.kind == gma_pkg::KIND_READ && cell_ok) begin
                r_out_data <= {cur_data.mass, cur_data.vel_x, cur_data.vel_y};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_stat.clr_last   = r_clr == gma_pkg::AW'(gma_pkg::CELLS - 1);
    assign o_stat.kind       = r_in.kind;
    assign o_stat.inj_skip   = !cell_ok || r_in.add_mass == '0;
    assign o_stat.src_empty  = cur_data.mass == '0;
    assign o_stat.src_last   = int'(r_sx) == gma_pkg::GRID_W - 1 &&
                               int'(r_sy) == gma_pkg::GRID_H - 1 &&
                               int'(r_ss) == gma_pkg::SPECIES_N - 1;
    assign o_stat.share_zero = r_share == '0;
    assign o_stat.off_last   = r_ox == gma_pkg::OFF_POS && r_oy == gma_pkg::OFF_POS;
    assign o_stat.mul_busy   = busy_x || busy_y;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

`ifndef SYNTH
    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_upd || i_cmd.load_inj) |=> r_tot != '0)
        else $error("merge loaded with zero total mass");
`endif

endmodule

[hdl/grid_mass_advection_step_core.sv]
// Channel   Direction  Handshake              Payload
// in        input      i_in_valid/o_in_stall   i_in_data  (gma_pkg::t_in_item)
// out       output     o_out_valid/i_out_stall o_out_data (gma_pkg::t_out_item)
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_data (gravity, 24 bits)
//
// A read and an inject of zero mass skip the merge; an inject that merges waits on the
// 32-step multiply and 33-step divide of the velocity blend.
// An update clears the scratch bank, then visits every cell; each occupied cell spreads
// over nine target cells, and each nonzero share is merged through the multiply-divide.
// After reset the grid bank is cleared before an item is taken.
// A waiting result sits in the output register while the next request is accepted.
module grid_mass_advection_step_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gma_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gma_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [23:0]        i_cfg_data
);

    gma_pkg::t_cmd  cmd;
    gma_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    gma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gma_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

[tb/tb_grid_mass_advection_step_core.sv]
`timescale 1ns / 100ps

module tb_grid_mass_advection_step_core;

    localparam int NUM_CELLS  = gma_pkg::GRID_W * gma_pkg::GRID_H * gma_pkg::SPECIES_N;
    localparam int PHASE_REQS = 250;
    localparam int PHASES     = 5;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef struct {
        gma_pkg::t_in_item  req;
        bit                 known;
        gma_pkg::t_out_item want;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    gma_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    gma_pkg::t_out_item o_out_data;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [23:0]        i_cfg_data;

    grid_mass_advection_step_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the grid and the gravity register.
    logic [31:0]        mass_q[NUM_CELLS];
    logic signed [31:0] velx_q[NUM_CELLS];
    logic signed [31:0] vely_q[NUM_CELLS];
    logic [31:0]        mass_n[NUM_CELLS];
    logic signed [31:0] velx_n[NUM_CELLS];
    logic signed [31:0] vely_n[NUM_CELLS];
    logic [23:0]        gravity_q;

    gma_pkg::t_out_item pending_reads[$];
    int  err_cnt;
    int  req_cnt;
    int  upd_cnt;
    int  resp_cnt;
    bit  quiet;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic int cell_of(int x, int y, int s);
        return (x * gma_pkg::GRID_H + y) * gma_pkg::SPECIES_N + s;
    endfunction

    function automatic logic signed [31:0] blend_vel(logic signed [31:0] ov,
                                                     logic signed [31:0] nv,
                                                     bit [63:0] added, bit [63:0] total);
        longint    d;
        bit [63:0] mag;
        bit [63:0] q;
        d   = longint'(nv) - longint'(ov);
        mag = (d < 0) ? 64'(-d) : 64'(d);
        q   = mag * added / total;
        if (d < 0)
            return 32'(longint'(ov) - longint'(q));
        return 32'(longint'(ov) + longint'(q));
    endfunction

    function automatic void merge_cell(inout logic [31:0] m, inout logic signed [31:0] vx,
                                       inout logic signed [31:0] vy, input logic [31:0] am,
                                       input logic signed [31:0] avx,
                                       input logic signed [31:0] avy);
        bit [63:0] total;
        if (am == 0)
            return;
        total = 64'(m) + 64'(am);
        vx = blend_vel(vx, avx, 64'(am), total);
        vy = blend_vel(vy, avy, 64'(am), total);
        m  = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
    endfunction

    function automatic bit [16:0] step_len(logic signed [31:0] v, logic [15:0] dt,
                                           output int sgn);
        bit [63:0] mag;
        mag = (v < 0) ? 64'(-longint'(v)) : 64'(v);
        mag = (mag * 64'(dt)) >> 16;
        if (mag > 64'(gma_pkg::UNIT_Q16))
            mag = 64'(gma_pkg::UNIT_Q16);
        sgn = (mag == 0) ? 0 : ((v < 0) ? -1 : 1);
        return mag[16:0];
    endfunction

    function automatic bit [63:0] axis_frac(int off, int sgn, bit [16:0] a);
        if (off == 0)
            return 64'(gma_pkg::UNIT_Q16) - 64'(a);
        return (sgn != 0 && off == sgn) ? 64'(a) : 64'd0;
    endfunction

    function automatic void advect_grid(logic [15:0] dt);
        longint             g;
        longint             vy64;
        logic signed [31:0] vy;
        bit [16:0]          ax;
        bit [16:0]          ay;
        int                 sx;
        int                 sy;
        int                 i;
        int                 tx;
        int                 ty;
        bit [63:0]          w;
        bit [63:0]          share;
        g = longint'((64'(gravity_q) * 64'(dt)) >> 16);
        for (int c = 0; c < NUM_CELLS; c++) begin
            mass_n[c] = '0;
            velx_n[c] = '0;
            vely_n[c] = '0;
        end
        for (int x = 0; x < gma_pkg::GRID_W; x++)
            for (int y = 0; y < gma_pkg::GRID_H; y++)
                for (int s = 0; s < gma_pkg::SPECIES_N; s++) begin
                    i = cell_of(x, y, s);
                    if (mass_q[i] != 0) begin
                        vy64 = longint'(vely_q[i]) - g;
                        if (vy64 < -64'sd2147483648)
                            vy64 = -64'sd2147483648;
                        vy = 32'(vy64);
                        ax = step_len(velx_q[i], dt, sx);
                        ay = step_len(vy, dt, sy);
                        for (int ox = -1; ox <= 1; ox++)
                            for (int oy = -1; oy <= 1; oy++) begin
                                tx = x + ox;
                                ty = y + oy;
                                if (tx >= 0 && ty >= 0 && tx < gma_pkg::GRID_W &&
                                    ty < gma_pkg::GRID_H) begin
                                    w = axis_frac(ox, sx, ax) * axis_frac(oy, sy, ay);
                                    share = (64'(mass_q[i]) * w) >> 32;
                                    merge_cell(mass_n[cell_of(tx, ty, s)],
                                               velx_n[cell_of(tx, ty, s)],
                                               vely_n[cell_of(tx, ty, s)],
                                               share[31:0], velx_q[i], vy);
                                end
                            end
                    end
                end
        for (int c = 0; c < NUM_CELLS; c++) begin
            mass_q[c] = mass_n[c];
            velx_q[c] = velx_n[c];
            vely_q[c] = vely_n[c];
        end
    endfunction

    // Applies one request to the shadow grid and returns what it reads back.
    function automatic gma_pkg::t_out_item apply_request(gma_pkg::t_in_item r);
        gma_pkg::t_out_item res;
        int                 i;
        res = '0;
        i = cell_of(int'(r.cell_x), int'(r.cell_y), int'(r.species));
        case (r.kind)
            gma_pkg::KIND_INJECT: begin
                merge_cell(mass_q[i], velx_q[i], vely_q[i], r.add_mass, r.add_vel_x,
                           r.add_vel_y);
            end
            gma_pkg::KIND_UPDATE: begin
                advect_grid(r.delta_time);
            end
            gma_pkg::KIND_READ: begin
                res.out_mass  = mass_q[i];
                res.out_vel_x = velx_q[i];
                res.out_vel_y = vely_q[i];
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic int idle_len();
        int p;
        if (quiet)
            return 0;
        p = $urandom_range(99);
        if (p < 65)
            return 0;
        if (p < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic t_row mk_row(logic [1:0] kind, int x, int y, int s, logic [31:0] m,
                                    logic [31:0] vx, logic [31:0] vy, logic [15:0] dt,
                                    bit known, logic [31:0] wm, logic [31:0] wx,
                                    logic [31:0] wy);
        t_row r;
        r.req.kind       = kind;
        r.req.cell_x     = 6'(x);
        r.req.cell_y     = 6'(y);
        r.req.species    = 2'(s);
        r.req.add_mass   = m;
        r.req.add_vel_x  = vx;
        r.req.add_vel_y  = vy;
        r.req.delta_time = dt;
        r.known          = known;
        r.want.out_mass  = wm;
        r.want.out_vel_x = wx;
        r.want.out_vel_y = wy;
        return r;
    endfunction

    function automatic int pick_coord();
        // Mostly near the borders, so shares fall off the grid and cells stay few.
        if ($urandom_range(9) < 8)
            return ($urandom_range(1)) ? $urandom_range(3) : $urandom_range(63, 60);
        return $urandom_range(63);
    endfunction

    function automatic logic [31:0] pick_vel();
        int p;
        p = $urandom_range(9);
        if (p < 6)
            return 32'($signed($urandom_range(262144)) - 131072);
        if (p < 8)
            return 32'($urandom());
        return (p == 8) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    function automatic gma_pkg::t_in_item random_request();
        gma_pkg::t_in_item r;
        int                p;
        p = $urandom_range(999);
        r.kind = (p < 8) ? gma_pkg::KIND_UPDATE : (p < 40) ? KIND_SPARE :
                 (p < 500) ? gma_pkg::KIND_INJECT : gma_pkg::KIND_READ;
        r.cell_x  = 6'(pick_coord());
        r.cell_y  = 6'(pick_coord());
        r.species = 2'($urandom_range(3));
        p = $urandom_range(9);
        r.add_mass = (p < 5) ? 32'($urandom_range(1 << 20)) :
                     (p < 8) ? 32'($urandom()) : (p == 8) ? 32'h0 : 32'hFFFF_FFFF;
        r.add_vel_x = pick_vel();
        r.add_vel_y = pick_vel();
        p = $urandom_range(9);
        r.delta_time = (p == 0) ? 16'h0 : (p == 1) ? 16'hFFFF : 16'($urandom());
        return r;
    endfunction

    task automatic send_request(t_row row);
        gma_pkg::t_out_item res;
        repeat (idle_len()) @(negedge i_clk);
        i_in_data  = row.req;
        i_in_valid = 1'b1;
        do
            @(posedge i_clk);
        while (o_in_stall);
        res = apply_request(row.req);
        pending_reads.push_back(row.known ? row.want : res);
        req_cnt++;
        if (row.req.kind == gma_pkg::KIND_UPDATE)
            upd_cnt++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic write_gravity(logic [23:0] value);
        wait (pending_reads.size() == 0);
        repeat (100) @(negedge i_clk);
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        gravity_q = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (quiet)
            i_out_stall = 1'b0;
        else if (idle_len() > 0)
            i_out_stall = 1'b1;
        else
            i_out_stall = 1'b0;
    end

    always @(posedge i_clk) begin
        gma_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            resp_cnt++;
            if (pending_reads.size() == 0) begin
                $display("%0t: unexpected response %h", $time, o_out_data);
                err_cnt++;
            end else begin
                want = pending_reads.pop_front();
                if (o_out_data.out_mass !== want.out_mass) begin
                    $display("%0t: out_mass expected %h actual %h", $time,
                             want.out_mass, o_out_data.out_mass);
                    err_cnt++;
                end
                if (o_out_data.out_vel_x !== want.out_vel_x) begin
                    $display("%0t: out_vel_x expected %h actual %h", $time,
                             want.out_vel_x, o_out_data.out_vel_x);
                    err_cnt++;
                end
                if (o_out_data.out_vel_y !== want.out_vel_y) begin
                    $display("%0t: out_vel_y expected %h actual %h", $time,
                             want.out_vel_y, o_out_data.out_vel_y);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #4s;
        $display("simulation failed");
        $finish;
    end

    initial begin
        t_row        directed[$];
        t_row        row;
        int          waited;
        logic [23:0] settings[PHASES];
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        err_cnt     = 0;
        req_cnt     = 0;
        upd_cnt     = 0;
        resp_cnt    = 0;
        quiet       = 1'b0;
        gravity_q   = gma_pkg::GRAVITY_RST;
        for (int c = 0; c < NUM_CELLS; c++) begin
            mass_q[c] = '0;
            velx_q[c] = '0;
            vely_q[c] = '0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty grid, spare kind, first fill of a cell, zero mass, saturation, updates.
        directed.push_back(mk_row(gma_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        directed.push_back(mk_row(KIND_SPARE, 7, 9, 1, 32'h1234, 5, 6, 16'h100, 1, 0, 0, 0));
        directed.push_back(mk_row(gma_pkg::KIND_INJECT, 0, 0, 0, 32'h10000, 32'h8000, 0, 0,
                                  1, 0, 0, 0));
        directed.push_back(mk_row(gma_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0,
                                  1, 32'h10000, 32'h8000, 0));
        directed.push_back(mk_row(gma_pkg::KIND_INJECT, 0, 0, 0, 0, 123, 456, 0, 1, 0, 0, 0));
        directed.push_back(mk_row(gma_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0,
                                  1, 32'h10000, 32'h8000, 0));
        directed.push_back(mk_row(gma_pkg::KIND_INJECT, 63, 63, 3, 32'hFFFF_FFFF,
                                  32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1, 0, 0, 0));
        directed.push_back(mk_row(gma_pkg::KIND_READ, 63, 63, 3, 0, 0, 0, 0, 1,
                                  32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        directed.push_back(mk_row(gma_pkg::KIND_INJECT, 63, 63, 3, 1, 0, 0, 0, 1, 0, 0, 0));
        directed.push_back(mk_row(gma_pkg::KIND_READ, 63, 63, 3, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(gma_pkg::KIND_INJECT, 32, 0, 1, 32'h20000, -32'sh30000,
                                  32'h10000, 0, 1, 0, 0, 0));
        directed.push_back(mk_row(gma_pkg::KIND_UPDATE, 0, 0, 0, 0, 0, 0, 16'h8000,
                                  1, 0, 0, 0));
        directed.push_back(mk_row(gma_pkg::KIND_READ, 32, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(gma_pkg::KIND_READ, 31, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(gma_pkg::KIND_READ, 32, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(gma_pkg::KIND_UPDATE, 0, 0, 0, 0, 0, 0, 16'hFFFF,
                                  1, 0, 0, 0));
        directed.push_back(mk_row(gma_pkg::KIND_READ, 63, 63, 3, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(gma_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(gma_pkg::KIND_INJECT, 5, 5, 2, 32'h30000, 0, 0, 0,
                                  1, 0, 0, 0));
        directed.push_back(mk_row(gma_pkg::KIND_INJECT, 5, 5, 2, 32'h10000, 32'h40000,
                                  -32'sh40000, 0, 1, 0, 0, 0));
        directed.push_back(mk_row(gma_pkg::KIND_READ, 5, 5, 2, 0, 0, 0, 0, 0, 0, 0, 0));

        write_gravity(gma_pkg::GRAVITY_RST);
        foreach (directed[k])
            send_request(directed[k]);

        settings[0] = 24'd0;
        settings[1] = 24'hFF_FFFF;
        settings[2] = 24'($urandom());
        settings[3] = 24'($urandom_range(1 << 20));
        settings[4] = gma_pkg::GRAVITY_RST;
        for (int ph = 0; ph < PHASES; ph++) begin
            write_gravity(settings[ph]);
            quiet = (ph == 2);
            for (int k = 0; k < PHASE_REQS; k++) begin
                row.req   = random_request();
                row.known = 1'b0;
                row.want  = '0;
                send_request(row);
            end
        end

        waited = 0;
        while (pending_reads.size() != 0 && waited < 20000000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (200) @(posedge i_clk);
        $display("Sent %0d requests (%0d grid updates) over %0d gravity settings,",
                 req_cnt, upd_cnt, PHASES + 1);
        $display("checked %0d responses, %0d still pending, %0d mismatches.",
                 resp_cnt, pending_reads.size(), err_cnt);
        if (err_cnt == 0 && pending_reads.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
